// ===== rtl/cpsat_pkg.sv =====
// Shared constants, command type and address helper for the polygon overlap block.
package cpsat_pkg;

  localparam int MAX_VERTS   = 8;
  localparam int COORD_W     = 16;
  localparam int STORE_DEPTH = 2 * MAX_VERTS;
  localparam int IDX_W       = $clog2(MAX_VERTS);
  localparam int CNT_W       = $clog2(MAX_VERTS + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int WORD_W      = 2 * COORD_W;
  localparam int AXIS_W      = COORD_W + 1;
  localparam int PROD_W      = COORD_W + AXIS_W;
  localparam int DOT_W       = PROD_W + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One queued command: an optional vertex write and an optional test start
  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
    logic              test;
    logic [CNT_W-1:0]  cnt_a;
    logic [CNT_W-1:0]  cnt_b;
    logic              ovf;
  } cmd_t;

  // Map a polygon select and vertex index to a store address
  function automatic logic [ADDR_W-1:0] addr_of(input logic poly, input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] base;
    base = poly ? ADDR_W'(MAX_VERTS) : '0;
    return base + ADDR_W'(idx);
  endfunction

endpackage

// ===== rtl/cpsat_queue.sv =====
// Short command queue between the vertex front end and the test engine.
module cpsat_queue import cpsat_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t                q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = q_mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/cpsat_front.sv =====
// Vertex front end: counts vertices per polygon, drops overflow, issues commands.
module cpsat_front import cpsat_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_poly_select,
  input  logic signed [15:0] in_vert_x,
  input  logic signed [15:0] in_vert_y,
  input  logic               in_end_of_pair,
  output logic               push,
  output cmd_t               push_cmd,
  input  logic               q_full
);

  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0] cnt_b_r, cnt_b_nxt;
  logic             ovf_r, ovf_nxt;
  logic             accept;
  logic             fits;
  logic [CNT_W-1:0] cnt_sel;
  logic [CNT_W-1:0] upd_a, upd_b;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign cnt_sel  = in_poly_select ? cnt_b_r : cnt_a_r;
  assign fits     = (cnt_sel < CNT_W'(MAX_VERTS));

  // Classify the vertex and build the command
  always_comb begin
    upd_a = cnt_a_r;
    upd_b = cnt_b_r;
    if (fits && !in_poly_select) begin
      upd_a = cnt_a_r + CNT_W'(1);
    end
    if (fits && in_poly_select) begin
      upd_b = cnt_b_r + CNT_W'(1);
    end
    push_cmd.wr    = fits;
    push_cmd.addr  = addr_of(in_poly_select, cnt_sel[IDX_W-1:0]);
    push_cmd.word  = {in_vert_y[COORD_W-1:0], in_vert_x[COORD_W-1:0]};
    push_cmd.test  = in_end_of_pair;
    push_cmd.cnt_a = upd_a;
    push_cmd.cnt_b = upd_b;
    push_cmd.ovf   = ovf_r || !fits;
    push           = accept && (fits || in_end_of_pair);

    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      if (in_end_of_pair) begin
        cnt_a_nxt = '0;
        cnt_b_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        cnt_a_nxt = upd_a;
        cnt_b_nxt = upd_b;
        ovf_nxt   = ovf_r || !fits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== rtl/cpsat_back.sv =====
// Test engine: vertex store, axis sequencer, projection pipeline and result register.
module cpsat_back import cpsat_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  cmd_t q_head,
  output logic q_pop,
  output logic out_valid,
  input  logic out_stall,
  output logic out_overlap,
  output logic out_vertex_overflow
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EDGE_S = 3'd1;
  localparam logic [2:0] ST_EDGE_E = 3'd2;
  localparam logic [2:0] ST_PROJ   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  localparam logic [1:0] K_EDGE_S = 2'd0;
  localparam logic [1:0] K_EDGE_E = 2'd1;
  localparam logic [1:0] K_PROJ_A = 2'd2;
  localparam logic [1:0] K_PROJ_B = 2'd3;

  logic [WORD_W-1:0] vstore [STORE_DEPTH];

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0] cnt_b_r, cnt_b_nxt;
  logic             ovf_r, ovf_nxt;
  logic             ax_poly_r, ax_poly_nxt;
  logic [IDX_W-1:0] ax_idx_r, ax_idx_nxt;
  logic             pr_poly_r, pr_poly_nxt;
  logic [IDX_W-1:0] pr_idx_r, pr_idx_nxt;
  logic             sep_r, sep_nxt;

  logic [CNT_W-1:0] ncur;
  logic             ax_wrap;
  logic [IDX_W-1:0] ax_nidx;
  logic             pr_end_a, pr_end_b;

  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [1:0]        rd_kind;
  logic              rd_first, rd_last;
  logic              load_out;

  // Read stage
  logic [WORD_W-1:0]         mem_q_r;
  logic                      s1_vld_r;
  logic [1:0]                s1_kind_r;
  logic                      s1_first_r, s1_last_r;
  logic signed [COORD_W-1:0] s1_x, s1_y;

  // Axis and product stage
  logic signed [COORD_W-1:0] p0_x_r, p0_y_r;
  logic signed [AXIS_W-1:0]  ax_r, ay_r;
  logic signed [PROD_W-1:0]  px_r, py_r;
  logic                      s2_vld_r;
  logic                      s2_poly_r, s2_first_r, s2_last_r;

  // Interval stage
  logic signed [DOT_W-1:0]   dot;
  logic signed [DOT_W-1:0]   lo_a_r, hi_a_r, lo_b_r, hi_b_r;
  logic                      cmp_r;

  logic out_valid_r, out_overlap_r, out_ovf_r;

  assign ncur     = ax_poly_r ? cnt_b_r : cnt_a_r;
  assign ax_wrap  = ((CNT_W'(ax_idx_r) + CNT_W'(1)) == ncur);
  assign ax_nidx  = ax_wrap ? '0 : ax_idx_r + IDX_W'(1);
  assign pr_end_a = ((CNT_W'(pr_idx_r) + CNT_W'(1)) == cnt_a_r);
  assign pr_end_b = ((CNT_W'(pr_idx_r) + CNT_W'(1)) == cnt_b_r);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Sequence store writes, edge reads and projection reads
  always_comb begin
    state_nxt   = state_r;
    cnt_a_nxt   = cnt_a_r;
    cnt_b_nxt   = cnt_b_r;
    ovf_nxt     = ovf_r;
    ax_poly_nxt = ax_poly_r;
    ax_idx_nxt  = ax_idx_r;
    pr_poly_nxt = pr_poly_r;
    pr_idx_nxt  = pr_idx_r;
    sep_nxt     = sep_r;
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    rd_kind     = K_EDGE_S;
    rd_first    = 1'b0;
    rd_last     = 1'b0;

    if (cmp_r && ((hi_a_r < lo_b_r) || (hi_b_r < lo_a_r))) begin
      sep_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        q_pop = !q_empty;
        wr_en = !q_empty && q_head.wr;
        if (!q_empty && q_head.test) begin
          cnt_a_nxt   = q_head.cnt_a;
          cnt_b_nxt   = q_head.cnt_b;
          ovf_nxt     = q_head.ovf;
          ax_poly_nxt = 1'b0;
          ax_idx_nxt  = '0;
          if ((q_head.cnt_a == '0) || (q_head.cnt_b == '0)) begin
            sep_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            sep_nxt   = 1'b0;
            state_nxt = ST_EDGE_S;
          end
        end
      end
      ST_EDGE_S: begin
        rd_en     = 1'b1;
        rd_addr   = addr_of(ax_poly_r, ax_idx_r);
        rd_kind   = K_EDGE_S;
        state_nxt = ST_EDGE_E;
      end
      ST_EDGE_E: begin
        rd_en       = 1'b1;
        rd_addr     = addr_of(ax_poly_r, ax_nidx);
        rd_kind     = K_EDGE_E;
        pr_poly_nxt = 1'b0;
        pr_idx_nxt  = '0;
        state_nxt   = ST_PROJ;
      end
      ST_PROJ: begin
        rd_en    = 1'b1;
        rd_addr  = addr_of(pr_poly_r, pr_idx_r);
        rd_kind  = pr_poly_r ? K_PROJ_B : K_PROJ_A;
        rd_first = (pr_idx_r == '0);
        rd_last  = pr_poly_r && pr_end_b;
        if (!pr_poly_r) begin
          if (pr_end_a) begin
            pr_poly_nxt = 1'b1;
            pr_idx_nxt  = '0;
          end else begin
            pr_idx_nxt = pr_idx_r + IDX_W'(1);
          end
        end else if (pr_end_b) begin
          // Axis finished: step to the next edge or drain
          if (ax_wrap) begin
            if (!ax_poly_r) begin
              ax_poly_nxt = 1'b1;
              ax_idx_nxt  = '0;
              state_nxt   = ST_EDGE_S;
            end else begin
              state_nxt = ST_DRAIN;
            end
          end else begin
            ax_idx_nxt = ax_nidx;
            state_nxt  = ST_EDGE_S;
          end
        end else begin
          pr_idx_nxt = pr_idx_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r && !cmp_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_a_r   <= '0;
      cnt_b_r   <= '0;
      ovf_r     <= 1'b0;
      ax_poly_r <= 1'b0;
      ax_idx_r  <= '0;
      pr_poly_r <= 1'b0;
      pr_idx_r  <= '0;
      sep_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_a_r   <= cnt_a_nxt;
      cnt_b_r   <= cnt_b_nxt;
      ovf_r     <= ovf_nxt;
      ax_poly_r <= ax_poly_nxt;
      ax_idx_r  <= ax_idx_nxt;
      pr_poly_r <= pr_poly_nxt;
      pr_idx_r  <= pr_idx_nxt;
      sep_r     <= sep_nxt;
    end
  end

  // Vertex store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vstore[q_head.addr] <= q_head.word;
    end
    if (rd_en) begin
      mem_q_r <= vstore[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r  <= rd_kind;
    s1_first_r <= rd_first;
    s1_last_r  <= rd_last;
  end

  assign s1_x = mem_q_r[COORD_W-1:0];
  assign s1_y = mem_q_r[WORD_W-1:COORD_W];

  // Latch edge start, form the normal (-ey, ex), multiply projections
  always_ff @(posedge clk) begin
    if (s1_vld_r && (s1_kind_r == K_EDGE_S)) begin
      p0_x_r <= s1_x;
      p0_y_r <= s1_y;
    end
    if (s1_vld_r && (s1_kind_r == K_EDGE_E)) begin
      ax_r <= AXIS_W'(p0_y_r) - AXIS_W'(s1_y);
      ay_r <= AXIS_W'(s1_x) - AXIS_W'(p0_x_r);
    end
    px_r       <= PROD_W'(s1_x) * PROD_W'(ax_r);
    py_r       <= PROD_W'(s1_y) * PROD_W'(ay_r);
    s2_poly_r  <= (s1_kind_r == K_PROJ_B);
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
  end

  assign dot = DOT_W'(px_r) + DOT_W'(py_r);

  // Track projection intervals per polygon
  always_ff @(posedge clk) begin
    if (s2_vld_r && !s2_poly_r) begin
      if (s2_first_r || (dot < lo_a_r)) begin
        lo_a_r <= dot;
      end
      if (s2_first_r || (dot > hi_a_r)) begin
        hi_a_r <= dot;
      end
    end
    if (s2_vld_r && s2_poly_r) begin
      if (s2_first_r || (dot < lo_b_r)) begin
        lo_b_r <= dot;
      end
      if (s2_first_r || (dot > hi_b_r)) begin
        hi_b_r <= dot;
      end
    end
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      cmp_r    <= 1'b0;
    end else begin
      s1_vld_r <= rd_en;
      s2_vld_r <= s1_vld_r && ((s1_kind_r == K_PROJ_A) || (s1_kind_r == K_PROJ_B));
      cmp_r    <= s2_vld_r && s2_last_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_overlap_r <= !sep_r;
      out_ovf_r     <= ovf_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_overlap         = out_overlap_r;
  assign out_vertex_overflow = out_ovf_r;

endmodule

// ===== rtl/convex_polygon_overlap_sat.sv =====
// Top level of the convex polygon overlap test by separating axes.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid/in_stall    poly_select, vert_x, vert_y, end_of_pair
//   out_      output     out_valid/out_stall  overlap, vertex_overflow
//
// Vertices are taken one per cycle while the command queue has room; each one that
// fits is written to the vertex store at the edge that removes it from the queue.
// With the engine idle and the queue otherwise empty, a test on nA and nB stored
// vertices makes one store read per cycle through the single read port and then
// raises out_valid; an empty polygon gives the result without any store reads.
// Reset clears counts, queue, sequencer and result valid; the store is not cleared.
// A stalled result holds the engine, and the queue then fills and stalls the input.
module convex_polygon_overlap_sat import cpsat_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_poly_select,
  input  logic signed [15:0] in_vert_x,
  input  logic signed [15:0] in_vert_y,
  input  logic               in_end_of_pair,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_overlap,
  output logic               out_vertex_overflow
);

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_push_cmd, q_head;

  cpsat_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_poly_select (in_poly_select),
    .in_vert_x      (in_vert_x),
    .in_vert_y      (in_vert_y),
    .in_end_of_pair (in_end_of_pair),
    .push           (q_push),
    .push_cmd       (q_push_cmd),
    .q_full         (q_full)
  );

  cpsat_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  cpsat_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_overlap         (out_overlap),
    .out_vertex_overflow (out_vertex_overflow)
  );

  // The front end never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("command pushed into full queue");

  // The engine never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("command popped from empty queue");

  // An accepted end-of-pair vertex leaves a test command queued
  a_eop_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_end_of_pair) |=> !q_empty)
    else $error("end-of-pair transfer left no queued command");

endmodule

// ===== bench/tb_convex_polygon_overlap_sat.sv =====
// Self-checking testbench for the separating axis polygon overlap block.
`timescale 1ns / 100ps

module tb_convex_polygon_overlap_sat;
  import cpsat_pkg::*;

  localparam int ITEMS       = 1700;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN       = 320;  // margin beyond the longest test
  localparam int COORD_SHIFT = 16 - ((COORD_W < 16) ? COORD_W : 16);
  localparam int DIR_ROWS    = 24;

  // Vertex offsets of a unit octagon, scaled by ten
  localparam int OCT_X [8] = '{10, 7, 0, -7, -10, -7, 0, 7};
  localparam int OCT_Y [8] = '{0, 7, 10, 7, 0, -7, -10, -7};

  typedef struct packed {
    logic overlap;
    logic overflow;
  } verdict_t;

  // One vertex transfer, with a typed verdict where the outcome is obvious
  typedef struct packed {
    logic        poly;
    logic [15:0] x;
    logic [15:0] y;
    logic        eop;
    logic        typed;
    logic        ovl;
    logic        ovf;
  } vertex_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_poly_select = 1'b0;
  logic signed [15:0] in_vert_x = '0;
  logic signed [15:0] in_vert_y = '0;
  logic               in_end_of_pair = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_overlap;
  logic               out_vertex_overflow;

  // Predicted block state
  logic signed [15:0] store_x [STORE_DEPTH];
  logic signed [15:0] store_y [STORE_DEPTH];
  int                 held_a = 0;
  int                 held_b = 0;
  bit                 overflow_seen = 1'b0;

  verdict_t           verdicts_due [$];
  vertex_row_t        shape_a [$];
  vertex_row_t        shape_b [$];
  int                 items_sent = 0;
  int                 fails = 0;
  int                 cycle_count = 0;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;

  // Directed part: empty polygons, field extremes, degenerate edges,
  // a separated pair, and a full store on the second polygon
  vertex_row_t directed_rows [DIR_ROWS] = '{
    '{1'b0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0},      // second polygon empty
    '{1'b1, 16'd5, 16'hFFFB, 1'b1, 1'b1, 1'b0, 1'b0},   // first polygon empty
    '{1'b0, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 16'd0, 16'h7FFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0},      // single point inside
    '{1'b0, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 1'b0, 1'b0}, // zero-length edge
    '{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 16'd10, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 16'd0, 16'd10, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 16'd20, 16'd20, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 16'd30, 16'd20, 1'b1, 1'b0, 1'b0, 1'b0},    // separated pair
    '{1'b1, 16'd100, 16'd1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 16'd200, 16'd2, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 16'd300, 16'd3, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 16'd400, 16'd4, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 16'd500, 16'd5, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 16'd600, 16'd6, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 16'd700, 16'd7, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 16'd800, 16'd8, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 16'd900, 16'd9, 1'b1, 1'b1, 1'b0, 1'b1}     // ninth vertex dropped
  };

  convex_polygon_overlap_sat uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_poly_select     (in_poly_select),
    .in_vert_x          (in_vert_x),
    .in_vert_y          (in_vert_y),
    .in_end_of_pair     (in_end_of_pair),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_overlap        (out_overlap),
    .out_vertex_overflow(out_vertex_overflow)
  );

  always #5 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare each result transfer with the oldest pending verdict
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        fails++;
        $display("%0t: unexpected result overlap %0b overflow %0b",
                 $time, out_overlap, out_vertex_overflow);
      end else begin
        verdict_t want;
        want = verdicts_due.pop_front();
        if (out_overlap !== want.overlap) begin
          fails++;
          $display("%0t: overlap expected %0b actual %0b", $time, want.overlap, out_overlap);
        end
        if (out_vertex_overflow !== want.overflow) begin
          fails++;
          $display("%0t: vertex_overflow expected %0b actual %0b",
                   $time, want.overflow, out_vertex_overflow);
        end
      end
    end
  end

  // Project the held vertices of one polygon onto an axis
  function automatic void project_onto(input int base, input int n, input longint ax,
                                       input longint ay, output longint lo, output longint hi);
    longint d;
    lo = 0;
    hi = 0;
    for (int i = 0; i < n; i++) begin
      d = longint'(store_x[base + i]) * ax + longint'(store_y[base + i]) * ay;
      if (i == 0 || d < lo) lo = d;
      if (i == 0 || d > hi) hi = d;
    end
  endfunction

  // True if some edge normal of the polygon at base splits the pair
  function automatic bit edge_separates(input int base, input int n);
    int     j;
    longint ex, ey, lo_a, hi_a, lo_b, hi_b;
    for (int i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      ex = longint'(store_x[base + j]) - longint'(store_x[base + i]);
      ey = longint'(store_y[base + j]) - longint'(store_y[base + i]);
      project_onto(0, held_a, -ey, ex, lo_a, hi_a);
      project_onto(MAX_VERTS, held_b, -ey, ex, lo_b, hi_b);
      if (hi_a < lo_b || hi_b < lo_a) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Store one vertex; on the end mark, work out the overlap verdict
  task automatic take_vertex(input logic poly, input logic [15:0] x, input logic [15:0] y,
                             input logic eop, output bit produced, output verdict_t v);
    logic signed [15:0] sx, sy;
    sx = x << COORD_SHIFT;
    sx = sx >>> COORD_SHIFT;
    sy = y << COORD_SHIFT;
    sy = sy >>> COORD_SHIFT;
    produced = 1'b0;
    v = '0;
    if (!poly) begin
      if (held_a < MAX_VERTS) begin
        store_x[held_a] = sx;
        store_y[held_a] = sy;
        held_a++;
      end else begin
        overflow_seen = 1'b1;
      end
    end else begin
      if (held_b < MAX_VERTS) begin
        store_x[MAX_VERTS + held_b] = sx;
        store_y[MAX_VERTS + held_b] = sy;
        held_b++;
      end else begin
        overflow_seen = 1'b1;
      end
    end
    if (!eop) return;
    produced   = 1'b1;
    v.overflow = overflow_seen;
    v.overlap  = !(held_a == 0 || held_b == 0 || edge_separates(0, held_a) ||
                   edge_separates(MAX_VERTS, held_b));
    held_a        = 0;
    held_b        = 0;
    overflow_seen = 1'b0;
  endtask

  // Drive one vertex transfer, then record what it should produce
  task automatic present_vertex(input vertex_row_t row);
    bit       produced;
    verdict_t v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_poly_select <= row.poly;
    in_vert_x      <= row.x;
    in_vert_y      <= row.y;
    in_end_of_pair <= row.eop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_vertex(row.poly, row.x, row.y, row.eop, produced, v);
    if (produced) begin
      if (row.typed) begin
        v.overlap  = row.ovl;
        v.overflow = row.ovf;
      end
      verdicts_due.push_back(v);
    end
    items_sent++;
  endtask

  // Mostly small shapes, a few that reach the coordinate limits
  function automatic int pick_radius();
    int c;
    c = $urandom_range(0, 9);
    if (c < 6) return $urandom_range(1, 200);
    if (c < 9) return $urandom_range(201, 3000);
    return $urandom_range(3001, 20000);
  endfunction

  // Pick a cyclic subset of octagon corners; any such subset stays convex
  task automatic fill_shape(input logic poly, input int cx, input int cy, input int r);
    int          mask, start, k, px, py;
    bit          reverse;
    vertex_row_t row;
    mask    = $urandom_range(1, 255);
    start   = $urandom_range(0, 7);
    reverse = 1'($urandom_range(0, 1));
    for (int i = 0; i < 8; i++) begin
      k = reverse ? (start - i + 8) % 8 : (start + i) % 8;
      if (mask[k]) begin
        px = cx + OCT_X[k] * r / 10;
        py = cy + OCT_Y[k] * r / 10;
        px = (px > 32767) ? 32767 : (px < -32768) ? -32768 : px;
        py = (py > 32767) ? 32767 : (py < -32768) ? -32768 : py;
        row      = '0;
        row.poly = poly;
        row.x    = px[15:0];
        row.y    = py[15:0];
        if (poly) shape_b.push_back(row);
        else shape_a.push_back(row);
      end
    end
  endtask

  // Two convex shapes near each other, vertices of both interleaved at random
  task automatic send_convex_pair();
    int          ra, rb, cx, cy, span;
    bit          take_b;
    vertex_row_t row;
    ra   = pick_radius();
    rb   = pick_radius();
    cx   = int'($urandom_range(0, 65535)) - 32768;
    cy   = int'($urandom_range(0, 65535)) - 32768;
    span = (ra + rb) * 5 / 4 + 1;
    shape_a.delete();
    shape_b.delete();
    fill_shape(1'b0, cx, cy, ra);
    fill_shape(1'b1, cx + int'($urandom_range(0, 2 * span)) - span,
               cy + int'($urandom_range(0, 2 * span)) - span, rb);
    while (shape_a.size() + shape_b.size() > 0) begin
      take_b = (shape_a.size() == 0) || (shape_b.size() != 0 && $urandom_range(0, 1) == 1);
      row = take_b ? shape_b.pop_front() : shape_a.pop_front();
      row.eop = (shape_a.size() + shape_b.size() == 0);
      present_vertex(row);
    end
  endtask

  // Arbitrary vertices, often overfilling one side of the store
  task automatic send_noise();
    int          len;
    vertex_row_t row;
    len = $urandom_range(1, 20);
    for (int i = 0; i < len; i++) begin
      row      = '0;
      row.poly = 1'($urandom_range(0, 1));
      row.x    = 16'($urandom());
      row.y    = 16'($urandom());
      row.eop  = (i == len - 1);
      present_vertex(row);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the idle phases: none, sender, receiver, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 79;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 79;
        end
        default: begin
          send_idle_pct = 27;
          stall_pct     = 27;
        end
      endcase
      if (phase == 0) begin
        for (int k = 0; k < DIR_ROWS; k++) present_vertex(directed_rows[k]);
      end
      while (items_sent < (phase + 1) * ITEMS / 4) begin
        if ($urandom_range(0, 9) < 7) send_convex_pair();
        else send_noise();
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding verdicts, then let the engine settle
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
